### hw/rtl/lse_pkg.sv
// Package for the lattice epidemic step block: field widths, codes, payload
// and controller/datapath interface types. No dependencies.
package lse_pkg;

  // Default configuration of the lattice
  localparam int unsigned SIDE_DEF      = 32;
  localparam int unsigned DRAW_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned COORD_W   = 5;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned REG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GEN_W     = 16;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned FR_OUT_W  = 13;
  localparam int unsigned CELL_W    = 2;

  // Item actions
  localparam logic [ACT_W-1:0] ACT_UPDATE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SWEEP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  // Neighbour directions
  localparam logic [DIR_W-1:0] DIR_ROW_INC = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ROW_DEC = 2'd1;
  localparam logic [DIR_W-1:0] DIR_COL_INC = 2'd2;
  localparam logic [DIR_W-1:0] DIR_COL_DEC = 2'd3;

  // Cell states
  localparam logic [CELL_W-1:0] CELL_SUS = 2'd0;
  localparam logic [CELL_W-1:0] CELL_INF = 2'd1;
  localparam logic [CELL_W-1:0] CELL_VAX = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_INFECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VACC   = 2'd1;
  localparam logic [REG_W-1:0]     INFECT_RST = 17'd65536;
  localparam logic [REG_W-1:0]     VACC_RST   = 17'd1022;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIR_W-1:0]   direction;
    logic [DRAW_W-1:0]  infect_draw;
    logic [DRAW_W-1:0]  vax_draw;
  } in_word_t;

  typedef struct packed {
    logic [GEN_W-1:0]     generation;
    logic [CNT_OUT_W-1:0] susceptible_count;
    logic [CNT_OUT_W-1:0] infected_count;
    logic [CNT_OUT_W-1:0] vaccinated_count;
    logic [FR_OUT_W-1:0]  frontier_pairs;
    logic                 done_res;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic upd_rd;    // read active and neighbour cell, latch the item
    logic upd_wr;    // resolve the update and write back
    logic cnt_clr;   // rewind the lattice walk, clear the tallies
    logic gen_clr;   // clear the generation counter
    logic clr_wr;    // write one cell of the initial lattice
    logic scan_rd;   // read one cell and its lower neighbour for the tally
    logic res_load;  // finish the sweep, load the result word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic k_last;    // walk pointer is at the last cell
  } sts_t;

endpackage

### hw/rtl/lattice_siv_epidemic_step_top.sv
// Top level of the lattice epidemic step block: ports, controller, datapath.
// Depends on lse_pkg, lse_ctrl, lse_dp.
//
// A SIDE x SIDE wrapping lattice of susceptible, infected and vaccinated cells
// lives in one two-read, one-write RAM. For an update word the active cell and
// its neighbour are read in the accept cycle, and at most one cell is written
// in the next. A sweep-end word walks the lattice one cell a cycle (each cell
// with its lower neighbour on the second read port), then presents its
// result; the next word is taken once the result is loaded into the output
// register, which holds it until taken. A restart word rewrites the lattice.
// After reset a clearing pass over all SIDE*SIDE cells (1024 by default)
// writes the initial lattice; in_stall_o stays high meanwhile. Configuration
// writes are always taken (cfg_ready_o is tied high); index 0 is the infection
// threshold, index 1 the vaccination threshold, other indexes are ignored.
module lattice_siv_epidemic_step_top
  import lse_pkg::*;
#(
  parameter int unsigned SIDE      = SIDE_DEF,
  parameter int unsigned DRAW_BITS = DRAW_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  lse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lse_dp #(
    .SIDE      (SIDE),
    .DRAW_BITS (DRAW_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

### hw/rtl/lse_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module lse_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hw/rtl/lse_ctrl.sv
// Controller of the lattice epidemic step block: sequences update, sweep,
// restart and clearing pass. Depends on lse_pkg.
module lse_ctrl
  import lse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] action_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Decode commands from state and accepted action
  always_comb begin
    cmd_o          = '0;
    cmd_o.upd_rd   = accept && (action_i == ACT_UPDATE);
    cmd_o.cnt_clr  = accept && ((action_i == ACT_SWEEP) || (action_i == ACT_RESTART));
    cmd_o.gen_clr  = accept && (action_i == ACT_RESTART);
    cmd_o.upd_wr   = (state_q == ST_UPD);
    cmd_o.clr_wr   = (state_q == ST_CLEAR);
    cmd_o.scan_rd  = (state_q == ST_SCAN);
    cmd_o.res_load = (state_q == ST_EMIT) && slot_free;
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.k_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority case (action_i)
            ACT_UPDATE:  state_d = ST_UPD;
            ACT_SWEEP:   state_d = ST_SCAN;
            ACT_RESTART: state_d = ST_CLEAR;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_UPD:   state_d = ST_IDLE;
      ST_SCAN: begin
        if (sts_i.k_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_one_ram_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.upd_rd, cmd_o.upd_wr, cmd_o.clr_wr, cmd_o.scan_rd}))
    else $error("more than one user of the cell RAM");
  a_upd_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $past(cmd_o.upd_rd))
    else $error("update write without its read cycle");
  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && ($past(state_q) != ST_EMIT) |-> ($past(state_q) == ST_DRAIN))
    else $error("result load without a drained sweep");
`endif

endmodule

### hw/rtl/lse_dp.sv
// Datapath of the lattice epidemic step block: cell RAM, walk counters,
// update resolution, sweep tallies and result register. Depends on lse_pkg, lse_ram.
module lse_dp
  import lse_pkg::*;
#(
  parameter int unsigned SIDE      = SIDE_DEF,
  parameter int unsigned DRAW_BITS = DRAW_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_word_t             in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output out_word_t            out_data_o
);

  localparam int unsigned CELLS  = SIDE * SIDE;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned RW     = $clog2(SIDE);
  localparam int unsigned CW     = (RW > COORD_W) ? RW : COORD_W;
  localparam int unsigned CENTER = (SIDE / 2) * SIDE + SIDE / 2;
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned F_W    = $clog2(4 * CELLS + 1);
  localparam logic [DRAW_W-1:0] DRAW_MASK =
    (DRAW_BITS >= DRAW_W) ? '1 : DRAW_W'((64'd1 << DRAW_BITS) - 64'd1);

  function automatic logic pair_hit(logic [CELL_W-1:0] x, logic [CELL_W-1:0] y);
    pair_hit = ((x == CELL_INF) && (y == CELL_SUS)) || ((x == CELL_SUS) && (y == CELL_INF));
  endfunction

  // Configuration registers
  logic [REG_W-1:0] ith_q, vth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ith_q <= INFECT_RST;
      vth_q <= VACC_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_INFECT) ith_q <= cfg_data_i;
      if (cfg_index_i == CFG_VACC)   vth_q <= cfg_data_i;
    end
  end

  // Walk counters: cell, cell one row below, column
  logic [AW-1:0] k_q, kd_q;
  logic [RW-1:0] col_q;
  logic          step;

  assign step         = cmd_i.clr_wr || cmd_i.scan_rd;
  assign sts_o.k_last = (k_q == AW'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      kd_q  <= AW'(SIDE);
      col_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      k_q   <= '0;
      kd_q  <= AW'(SIDE);
      col_q <= '0;
    end else if (step) begin
      k_q   <= sts_o.k_last ? '0 : k_q + AW'(1);
      kd_q  <= (kd_q == AW'(CELLS - 1)) ? '0 : kd_q + AW'(1);
      col_q <= (col_q == RW'(SIDE - 1)) ? '0 : col_q + RW'(1);
    end
  end

  // Active and neighbour address of an incoming update
  logic [CW-1:0] r_c, c_c, rn, cn;
  logic          in_range;
  logic [AW-1:0] act_addr, pas_addr;

  always_comb begin
    r_c      = CW'(in_data_i.row);
    c_c      = CW'(in_data_i.col);
    in_range = (32'(r_c) < SIDE) && (32'(c_c) < SIDE);
    rn       = r_c;
    cn       = c_c;
    unique case (in_data_i.direction)
      DIR_ROW_INC: rn = (32'(r_c) == SIDE - 1) ? '0 : r_c + CW'(1);
      DIR_ROW_DEC: rn = (r_c == '0) ? CW'(SIDE - 1) : r_c - CW'(1);
      DIR_COL_INC: cn = (32'(c_c) == SIDE - 1) ? '0 : c_c + CW'(1);
      DIR_COL_DEC: cn = (c_c == '0) ? CW'(SIDE - 1) : c_c - CW'(1);
      default:     cn = c_c;
    endcase
    act_addr = AW'(32'(r_c) * SIDE + 32'(c_c));
    pas_addr = AW'(32'(rn) * SIDE + 32'(cn));
  end

  // Latch the update item while its cells are read
  logic [AW-1:0]     act_q, pas_q;
  logic [DRAW_W-1:0] idraw_q, vdraw_q;
  logic              inr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_rd) begin
      act_q   <= act_addr;
      pas_q   <= pas_addr;
      idraw_q <= in_data_i.infect_draw & DRAW_MASK;
      vdraw_q <= in_data_i.vax_draw & DRAW_MASK;
      inr_q   <= in_range;
    end
  end

  // Cell RAM
  logic              we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [CELL_W-1:0] wdata, rd_a, rd_b;
  logic              inf_hit, vax_hit;

  assign raddr_a = cmd_i.scan_rd ? k_q  : act_addr;
  assign raddr_b = cmd_i.scan_rd ? kd_q : pas_addr;

  assign inf_hit = ({1'b0, idraw_q} < ith_q) && (rd_a == CELL_INF) && (rd_b == CELL_SUS);
  assign vax_hit = (rd_a == CELL_SUS) && ({1'b0, vdraw_q} < vth_q);

  // Pick the write: initial lattice, infection of the neighbour, vaccination
  always_comb begin
    we    = 1'b0;
    waddr = k_q;
    wdata = CELL_SUS;
    priority if (cmd_i.clr_wr) begin
      we    = 1'b1;
      wdata = (k_q == AW'(CENTER)) ? CELL_INF : CELL_SUS;
    end else if (cmd_i.upd_wr) begin
      we    = inr_q && (inf_hit || vax_hit);
      waddr = inf_hit ? pas_q : act_q;
      wdata = inf_hit ? CELL_INF : CELL_VAX;
    end else begin
      we    = 1'b0;
    end
  end

  lse_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  // Track which read data belongs to the sweep
  logic sc_vld_q, sc_first_q, sc_lastc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else begin
      sc_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_first_q <= (col_q == '0);
    sc_lastc_q <= (col_q == RW'(SIDE - 1));
  end

  // Tally cells and frontier pairs: each cell against its right and lower neighbour
  logic [CELL_W-1:0] prev_q, rowfirst_q, first_v;
  logic [CNT_W-1:0]  s_q, i_q, v_q;
  logic [F_W-1:0]    f_q;
  logic [1:0]        f_inc;

  always_comb begin
    first_v = sc_first_q ? rd_a : rowfirst_q;
    f_inc   = 2'(pair_hit(rd_a, rd_b))
            + 2'(!sc_first_q && pair_hit(prev_q, rd_a))
            + 2'(sc_lastc_q && pair_hit(rd_a, first_v));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) begin
      s_q <= '0;
      i_q <= '0;
      v_q <= '0;
      f_q <= '0;
    end else if (sc_vld_q) begin
      prev_q <= rd_a;
      if (sc_first_q) rowfirst_q <= rd_a;
      s_q <= s_q + CNT_W'(rd_a == CELL_SUS);
      i_q <= i_q + CNT_W'(rd_a == CELL_INF);
      v_q <= v_q + CNT_W'(rd_a == CELL_VAX);
      f_q <= f_q + F_W'(f_inc);
    end
  end

  // Generation counter, saturating
  logic [GEN_W-1:0] gen_q, gen_next;

  assign gen_next = (gen_q == '1) ? gen_q : gen_q + GEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cmd_i.gen_clr) begin
      gen_q <= '0;
    end else if (cmd_i.res_load) begin
      gen_q <= gen_next;
    end
  end

  // Load the result word
  out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.generation        <= gen_next;
      out_q.susceptible_count <= CNT_OUT_W'(s_q);
      out_q.infected_count    <= CNT_OUT_W'(i_q);
      out_q.vaccinated_count  <= CNT_OUT_W'(v_q);
      out_q.frontier_pairs    <= FR_OUT_W'(f_q);
      out_q.done_res          <= (s_q == '0) || (f_q == '0);
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_cells_add_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (32'(s_q) + 32'(i_q) + 32'(v_q) == CELLS))
    else $error("sweep tallies do not cover the lattice");
  a_frontier_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (32'(f_q) <= 4 * 32'(i_q)))
    else $error("more frontier pairs than infected cell sides");
  a_tally_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_vld_q |-> $past(cmd_i.scan_rd))
    else $error("tally without a sweep read");
`endif

endmodule

### bench/tb_lattice_siv_epidemic_step_top.sv
// Self-checking bench for the lattice epidemic step block: drives update, sweep-end,
// restart and unknown words, predicts every sweep report and checks each one.
// Depends on lse_pkg and lattice_siv_epidemic_step_top.
module tb_lattice_siv_epidemic_step_top
  import lse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE        = SIDE_DEF;
  localparam int unsigned CELLS       = SIDE * SIDE;
  localparam int unsigned CTR         = SIDE / 2;
  localparam int unsigned SETTLE      = CELLS + 16;
  localparam int unsigned QUIET_LIMIT = 8 * SETTLE;
  localparam int unsigned PHASE_WORDS = 380;

  // Codes the block has no use for
  localparam logic [ACT_W-1:0]     ACT_NONE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]     cfg_data_i  = '0;

  // Shadow lattice, sweep counter and thresholds
  logic [CELL_W-1:0] grid [CELLS];
  logic [GEN_W-1:0]  gen_count  = '0;
  logic [REG_W-1:0]  infect_thr = INFECT_RST;
  logic [REG_W-1:0]  vacc_thr   = VACC_RST;

  in_word_t    pending_words [$];
  out_word_t   sweep_reports [$];
  int unsigned mismatch_count = 0;
  int unsigned feed_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  bit          burst = 1'b0;

  lattice_siv_epidemic_step_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned next_cell(int unsigned r, int unsigned c,
                                            logic [DIR_W-1:0] d);
    int unsigned nr;
    int unsigned nc;
    nr = r;
    nc = c;
    case (d)
      DIR_ROW_INC: nr = (r + 1) % SIDE;
      DIR_ROW_DEC: nr = (r + SIDE - 1) % SIDE;
      DIR_COL_INC: nc = (c + 1) % SIDE;
      default:     nc = (c + SIDE - 1) % SIDE;
    endcase
    return nr * SIDE + nc;
  endfunction

  function automatic void seed_grid();
    int unsigned idx;
    for (idx = 0; idx < CELLS; idx++) grid[idx] = CELL_SUS;
    grid[CTR * SIDE + CTR] = CELL_INF;
    gen_count = '0;
  endfunction

  // Advance the shadow lattice by one accepted word, queue the report of a sweep
  function automatic void lattice_apply(in_word_t w);
    int unsigned act;
    int unsigned pas;
    int unsigned idx;
    int unsigned d;
    int unsigned s;
    int unsigned i;
    int unsigned v;
    int unsigned f;
    out_word_t   rep;
    case (w.action)
      ACT_UPDATE: begin
        act = int'(w.row) * SIDE + int'(w.col);
        pas = next_cell(w.row, w.col, w.direction);
        if (w.infect_draw < infect_thr && grid[act] == CELL_INF && grid[pas] == CELL_SUS)
          grid[pas] = CELL_INF;
        if (grid[act] == CELL_SUS && w.vax_draw < vacc_thr)
          grid[act] = CELL_VAX;
      end
      ACT_SWEEP: begin
        s = 0;
        i = 0;
        v = 0;
        f = 0;
        for (idx = 0; idx < CELLS; idx++) begin
          case (grid[idx])
            CELL_SUS: s++;
            CELL_INF: begin
              i++;
              for (d = 0; d < 4; d++)
                if (grid[next_cell(idx / SIDE, idx % SIDE, DIR_W'(d))] == CELL_SUS) f++;
            end
            CELL_VAX: v++;
            default: ;
          endcase
        end
        if (gen_count != {GEN_W{1'b1}}) gen_count++;
        rep.generation        = gen_count;
        rep.susceptible_count = CNT_OUT_W'(s);
        rep.infected_count    = CNT_OUT_W'(i);
        rep.vaccinated_count  = CNT_OUT_W'(v);
        rep.frontier_pairs    = FR_OUT_W'(f);
        rep.done_res          = (s == 0 || f == 0);
        sweep_reports.push_back(rep);
      end
      ACT_RESTART: seed_grid();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_report(out_word_t got);
    out_word_t want;
    if (sweep_reports.size() == 0) begin
      report_mismatch("report with no sweep pending, generation", got.generation, 0);
    end else begin
      want = sweep_reports.pop_front();
      if (got.generation != want.generation)
        report_mismatch("generation", got.generation, want.generation);
      if (got.susceptible_count != want.susceptible_count)
        report_mismatch("susceptible_count", got.susceptible_count, want.susceptible_count);
      if (got.infected_count != want.infected_count)
        report_mismatch("infected_count", got.infected_count, want.infected_count);
      if (got.vaccinated_count != want.vaccinated_count)
        report_mismatch("vaccinated_count", got.vaccinated_count, want.vaccinated_count);
      if (got.frontier_pairs != want.frontier_pairs)
        report_mismatch("frontier_pairs", got.frontier_pairs, want.frontier_pairs);
      if (got.done_res != want.done_res)
        report_mismatch("done_res", got.done_res, want.done_res);
    end
  endtask

  // Feed words to the block, one gap draw per word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      feed_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lattice_apply(in_data_i);
        feed_gap = burst ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_data_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Take sweep reports, hold each one for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_report(out_data_o);
        hold_left = burst ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  task automatic push_word(logic [ACT_W-1:0] act, int unsigned r, int unsigned c,
                           logic [DIR_W-1:0] d, int unsigned idraw, int unsigned vdraw);
    in_word_t w;
    w.action      = act;
    w.row         = COORD_W'(r);
    w.col         = COORD_W'(c);
    w.direction   = d;
    w.infect_draw = DRAW_W'(idraw);
    w.vax_draw    = DRAW_W'(vdraw);
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_INFECT) infect_thr = val;
    else if (idx == CFG_VACC) vacc_thr = val;
  endtask

  // Wait until every report is in, then let any lattice walk finish
  task automatic drain_and_settle();
    while (pending_words.size() != 0 || in_valid_i || sweep_reports.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Pick one infected cell / susceptible neighbour pair at random
  function automatic bit pick_frontier(output int unsigned site, output logic [DIR_W-1:0] dir);
    int unsigned total;
    int unsigned k;
    int unsigned idx;
    int unsigned d;
    total = 0;
    site  = 0;
    dir   = DIR_ROW_INC;
    for (idx = 0; idx < CELLS; idx++)
      if (grid[idx] == CELL_INF)
        for (d = 0; d < 4; d++)
          if (grid[next_cell(idx / SIDE, idx % SIDE, DIR_W'(d))] == CELL_SUS) total++;
    if (total == 0) return 1'b0;
    k = $urandom_range(0, total - 1);
    for (idx = 0; idx < CELLS; idx++)
      if (grid[idx] == CELL_INF)
        for (d = 0; d < 4; d++)
          if (grid[next_cell(idx / SIDE, idx % SIDE, DIR_W'(d))] == CELL_SUS) begin
            if (k == 0) begin
              site = idx;
              dir  = DIR_W'(d);
              return 1'b1;
            end
            k--;
          end
    return 1'b0;
  endfunction

  function automatic int unsigned pick_draw();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return {DRAW_W{1'b1}};
    return $urandom_range(0, (1 << DRAW_W) - 1);
  endfunction

  // Build an update word, mostly aimed at the infection front
  task automatic gen_update_word();
    int unsigned      site;
    logic [DIR_W-1:0] dir;
    int unsigned      r;
    int unsigned      c;
    r   = $urandom_range(0, SIDE - 1);
    c   = $urandom_range(0, SIDE - 1);
    dir = DIR_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 65 && pick_frontier(site, dir)) begin
      if ($urandom_range(0, 1) == 0) begin
        // infected cell toward its susceptible neighbour
        r = site / SIDE;
        c = site % SIDE;
      end else begin
        // the susceptible neighbour itself, open to vaccination
        site = next_cell(site / SIDE, site % SIDE, dir);
        r    = site / SIDE;
        c    = site % SIDE;
        dir  = DIR_W'($urandom_range(0, 3));
      end
    end
    push_word(ACT_UPDATE, r, c, dir, pick_draw(), pick_draw());
  endtask

  task automatic run_random(int unsigned n);
    int unsigned counted;
    int unsigned roll;
    logic [ACT_W-1:0] act;
    counted = 0;
    while (counted < n) begin
      while (pending_words.size() >= 2) @(negedge clk_i);
      if (counted % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 999);
      if (roll < 60) begin
        if (roll < 8) act = ACT_RESTART;
        else if (roll < 45) act = ACT_SWEEP;
        else act = ACT_NONE;
        push_word(act, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                  DIR_W'($urandom_range(0, 3)), pick_draw(), pick_draw());
        if (act != ACT_NONE) counted++;
      end else begin
        gen_update_word();
        counted++;
      end
    end
  endtask

  initial begin
    seed_grid();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset thresholds
    push_word(ACT_SWEEP, 0, 0, DIR_ROW_INC, 0, 0);
    push_word(ACT_NONE, SIDE - 1, SIDE - 1, DIR_COL_DEC, 16'hFFFF, 16'hFFFF);
    push_word(ACT_UPDATE, CTR, CTR, DIR_ROW_INC, 16'hFFFF, 16'hFFFF);
    push_word(ACT_UPDATE, CTR, CTR, DIR_ROW_DEC, 0, 0);
    push_word(ACT_UPDATE, CTR, CTR, DIR_COL_INC, 1, 1);
    push_word(ACT_UPDATE, CTR, CTR, DIR_COL_DEC, 16'h8000, 16'h8000);
    push_word(ACT_SWEEP, 0, 0, DIR_ROW_INC, 0, 0);
    // Corner cells wrap to the far edge; vaccination right at the threshold
    push_word(ACT_UPDATE, 0, 0, DIR_ROW_DEC, 0, 0);
    push_word(ACT_UPDATE, 0, 0, DIR_COL_DEC, 0, VACC_RST - 1);
    push_word(ACT_UPDATE, SIDE - 1, SIDE - 1, DIR_ROW_INC, 0, VACC_RST);
    push_word(ACT_UPDATE, SIDE - 1, SIDE - 1, DIR_COL_INC, 0, VACC_RST - 1);
    push_word(ACT_SWEEP, SIDE - 1, SIDE - 1, DIR_COL_DEC, 16'hFFFF, 16'hFFFF);
    push_word(ACT_RESTART, 0, 0, DIR_ROW_INC, 0, 0);
    push_word(ACT_SWEEP, 0, 0, DIR_ROW_INC, 0, 0);
    // Ring the seed with vaccinated cells: no frontier left
    push_word(ACT_UPDATE, CTR + 1, CTR, DIR_ROW_DEC, 0, 0);
    push_word(ACT_UPDATE, CTR - 1, CTR, DIR_ROW_INC, 0, 0);
    push_word(ACT_UPDATE, CTR, CTR + 1, DIR_COL_DEC, 0, 0);
    push_word(ACT_UPDATE, CTR, CTR - 1, DIR_COL_INC, 0, 0);
    push_word(ACT_SWEEP, 0, 0, DIR_ROW_INC, 0, 0);
    push_word(ACT_UPDATE, CTR, CTR, DIR_ROW_INC, 0, 0);
    push_word(ACT_SWEEP, 0, 0, DIR_ROW_INC, 0, 0);
    push_word(ACT_RESTART, SIDE - 1, SIDE - 1, DIR_COL_DEC, 16'hFFFF, 16'hFFFF);
    drain_and_settle();

    // Infection off, vaccination always
    write_reg(CFG_INFECT, 17'd0);
    write_reg(CFG_VACC, 17'd65536);
    run_random(PHASE_WORDS);
    drain_and_settle();

    // Even odds of infection, reset vaccination rate
    write_reg(CFG_INFECT, 17'd32768);
    write_reg(CFG_VACC, VACC_RST);
    run_random(PHASE_WORDS);
    drain_and_settle();

    // Infection fails only on the top draw, vaccination off
    write_reg(CFG_INFECT, 17'd65535);
    write_reg(CFG_VACC, 17'd0);
    run_random(PHASE_WORDS);
    drain_and_settle();

    // All-ones threshold, writes to unused indexes
    write_reg(CFG_INFECT, 17'h1FFFF);
    write_reg(CFG_VACC, 17'd8192);
    write_reg(CFG_UNUSED_A, 17'h1FFFF);
    write_reg(CFG_UNUSED_B, 17'd0);
    run_random(PHASE_WORDS);
    drain_and_settle();

    // Random infection threshold over the full register range, vaccination up to 16384
    write_reg(CFG_INFECT, REG_W'($urandom_range(0, (1 << REG_W) - 1)));
    write_reg(CFG_VACC, REG_W'($urandom_range(0, 16384)));
    write_reg(CFG_UNUSED_B, 17'h1FFFF);
    run_random(PHASE_WORDS);
    drain_and_settle();

    if (sweep_reports.size() != 0)
      report_mismatch("sweep reports never delivered", 0, sweep_reports.size());
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
